// ===== rtl/cmpc_pkg.sv =====
// Shared types, constants and the control program of the cascade motor position controller.
`default_nettype none

package cmpc_pkg;

  // Field and datapath widths.
  localparam int unsigned ANGLE_W    = 13;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned TURNS_W    = 16;
  localparam int unsigned POS_W      = 29;
  localparam int unsigned CURR_W     = 14;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned ERR_W      = POS_W + 1;
  localparam int unsigned INTEG_W    = 32;
  localparam int unsigned MUL_A_W    = GAIN_W + 1;
  localparam int unsigned MUL_B_W    = INTEG_W;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W      = PROD_W + 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned QUOT_W     = ACC_W - FRAC_W;
  localparam int unsigned DIFF_W     = 18;
  localparam int unsigned POS_CALC_W = TURNS_W + 18;

  // Port widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 64;

  // Motor and loop constants.
  localparam int COUNTS_PER_TURN = 8192;
  localparam int WRAP_THRESHOLD  = 4000;
  localparam int CURRENT_LIMIT   = 7000;

  // Register reset values (Q16.16 gains of 23.0 and about 0.001).
  localparam logic [GAIN_W-1:0] SPEED_PROP_GAIN_RST = 32'd1507328;
  localparam logic [GAIN_W-1:0] SPEED_INT_GAIN_RST  = 32'd66;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_POSITION = 2'd0,
    CFG_POSITION_GAIN   = 2'd1,
    CFG_SPEED_PROP_GAIN = 2'd2,
    CFG_SPEED_INT_GAIN  = 2'd3
  } cfg_index_t;

  // Multiplier operand pair selection.
  typedef enum logic [1:0] {
    MUL_NONE     = 2'd0,
    MUL_POSITION = 2'd1,
    MUL_PROP     = 2'd2,
    MUL_INT      = 2'd3
  } mul_sel_t;

  // Accumulator operation.
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_NUM  = 2'd1,
    ACC_LOAD = 2'd2,
    ACC_ADD  = 2'd3
  } acc_op_t;

  // Sequencer branch kind.
  typedef enum logic [1:0] {
    JMP_NONE        = 2'd0,
    JMP_IF_FEEDBACK = 2'd1,
    JMP_ALWAYS      = 2'd2
  } jump_t;

  localparam int unsigned STEP_W = 4;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_ERR  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MULP = 4'd1;
  localparam logic [STEP_W-1:0] STEP_NUM  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_VERR = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SUM  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LDP  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ADDI = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CMD  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_OUT  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FB   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_POS  = 4'd10;

  // One control word of the program.
  typedef struct packed {
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    logic              err_en;
    logic              verr_en;
    logic              sum_en;
    logic              cmd_en;
    logic              fb_en;
    logic              pos_en;
    logic              done;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } uop_t;

  // Sequencer to datapath control.
  typedef struct packed {
    logic load;
    uop_t uop;
  } seq_ctrl_t;

  // Datapath to sequencer status.
  typedef struct packed {
    logic is_tick;
    logic out_stall;
  } dp_status_t;

  // Control store: a tick runs the cascade loop, feedback unwraps the angle.
  function automatic uop_t ucode(input logic [STEP_W-1:0] addr);
    uop_t u;
    u = '0;
    case (addr)
      STEP_ERR: begin
        u.err_en = 1'b1;
        u.jump   = JMP_IF_FEEDBACK;
        u.target = STEP_FB;
      end
      STEP_MULP: u.mul_sel = MUL_POSITION;
      STEP_NUM:  u.acc_op  = ACC_NUM;
      STEP_VERR: u.verr_en = 1'b1;
      STEP_SUM: begin
        u.sum_en  = 1'b1;
        u.mul_sel = MUL_PROP;
      end
      STEP_LDP: begin
        u.acc_op  = ACC_LOAD;
        u.mul_sel = MUL_INT;
      end
      STEP_ADDI: u.acc_op = ACC_ADD;
      STEP_CMD:  u.cmd_en = 1'b1;
      STEP_OUT:  u.done   = 1'b1;
      STEP_FB:   u.fb_en  = 1'b1;
      STEP_POS: begin
        u.pos_en = 1'b1;
        u.jump   = JMP_ALWAYS;
        u.target = STEP_OUT;
      end
      default: begin
        u.done = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cmpc_sequencer.sv =====
// Step counter and control store that sequence one item through the datapath.
`default_nettype none

module cmpc_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_valid,
  output logic                   s_ready,
  input  cmpc_pkg::dp_status_t   status,
  output cmpc_pkg::seq_ctrl_t    ctrl
);
  import cmpc_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  uop_t              uop;
  logic              accept;
  logic              exec;
  logic              take_jump;

  // Fetch the control word of the current step.
  assign uop     = ucode(step);
  assign s_ready = !busy;
  assign accept  = s_valid && !busy;

  // The final step waits while the previous result is still unread.
  assign exec      = busy && !(uop.done && status.out_stall);
  assign take_jump = (uop.jump == JMP_ALWAYS) ||
                     ((uop.jump == JMP_IF_FEEDBACK) && !status.is_tick);

  always_comb begin
    ctrl.load = accept;
    ctrl.uop  = exec ? uop : '0;
  end

  // Step counter with branches.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_ERR;
    end else if (accept) begin
      busy <= 1'b1;
      step <= STEP_ERR;
    end else if (exec) begin
      if (uop.done) begin
        busy <= 1'b0;
      end else if (take_jump) begin
        step <= uop.target;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cmpc_datapath.sv =====
// Registers, shared multiplier, accumulator and saturation logic of the controller.
`default_nettype none

module cmpc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cmpc_pkg::seq_ctrl_t                 ctrl,
  output cmpc_pkg::dp_status_t                status,
  input  logic [cmpc_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  input  logic                                cfg_we,
  input  logic [cmpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cmpc_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tuser
);
  import cmpc_pkg::*;

  localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'((64'sd1 <<< FRAC_W) - 64'sd1);
  localparam logic signed [QUOT_W-1:0] Q_I32_MAX  = QUOT_W'(64'sd2147483647);
  localparam logic signed [QUOT_W-1:0] Q_I32_MIN  = QUOT_W'(-64'sd2147483648);
  localparam logic signed [QUOT_W-1:0] Q_LIM      = QUOT_W'(CURRENT_LIMIT);
  localparam logic signed [CURR_W-1:0] CURR_MAX   = CURR_W'(CURRENT_LIMIT);
  localparam logic signed [CURR_W-1:0] CURR_MIN   = CURR_W'(-CURRENT_LIMIT);
  localparam logic signed [INTEG_W-1:0] I32_MAX   = 32'sh7fffffff;
  localparam logic signed [INTEG_W-1:0] I32_MIN   = 32'sh80000000;
  localparam logic signed [DIFF_W-1:0] WRAP_LIM   = DIFF_W'(WRAP_THRESHOLD);

  // Configuration registers.
  logic signed [POS_W-1:0]  target_position;
  logic [GAIN_W-1:0]        position_gain;
  logic [GAIN_W-1:0]        speed_prop_gain;
  logic [GAIN_W-1:0]        speed_int_gain;

  // Latched input item.
  logic                     item_tick;
  logic [ANGLE_W-1:0]       item_angle;
  logic signed [SPEED_W-1:0] item_speed;

  // Controller state.
  logic [ANGLE_W-1:0]       angle;
  logic signed [TURNS_W-1:0] turns;
  logic signed [SPEED_W-1:0] stored_speed;
  logic signed [INTEG_W-1:0] speed_error_sum;
  logic signed [CURR_W-1:0] last_command;
  logic signed [POS_W-1:0]  position;

  // Working registers.
  logic signed [ERR_W-1:0]  err;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [INTEG_W-1:0] verr;

  // Output register.
  logic signed [CURR_W-1:0] out_current;
  logic signed [TURNS_W-1:0] out_turns;
  logic signed [POS_W-1:0]  out_position;

  // Combinational terms.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   speed_term;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [QUOT_W-1:0]  quot;
  logic signed [INTEG_W-1:0] verr_next;
  logic signed [INTEG_W:0]   sum_wide;
  logic signed [INTEG_W-1:0] sum_next;
  logic signed [CURR_W-1:0]  cmd_next;
  logic signed [DIFF_W-1:0]  angle_diff;
  logic signed [TURNS_W-1:0] turns_next;
  logic signed [POS_CALC_W-1:0] pos_calc;

  assign status.is_tick   = item_tick;
  assign status.out_stall = m_tvalid && !m_tready;

  // Shared multiplier operand selection.
  always_comb begin
    case (ctrl.uop.mul_sel)
      MUL_POSITION: begin
        mul_a = $signed({1'b0, position_gain});
        mul_b = MUL_B_W'(err);
      end
      MUL_PROP: begin
        mul_a = $signed({1'b0, speed_prop_gain});
        mul_b = verr;
      end
      MUL_INT: begin
        mul_a = $signed({1'b0, speed_int_gain});
        mul_b = speed_error_sum;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Speed feedback scaled to the Q16.16 product.
  assign speed_term = ACC_W'(stored_speed) <<< FRAC_W;

  // Division by 2^16 that truncates toward zero.
  assign acc_rnd = acc + (acc[ACC_W-1] ? ROUND_BIAS : '0);
  assign quot    = acc_rnd[ACC_W-1:FRAC_W];

  // Velocity error saturated to 32 bits.
  always_comb begin
    if (quot > Q_I32_MAX) begin
      verr_next = I32_MAX;
    end else if (quot < Q_I32_MIN) begin
      verr_next = I32_MIN;
    end else begin
      verr_next = quot[INTEG_W-1:0];
    end
  end

  // Saturating integrator.
  assign sum_wide = {speed_error_sum[INTEG_W-1], speed_error_sum} + {verr[INTEG_W-1], verr};
  always_comb begin
    if (sum_wide[INTEG_W] != sum_wide[INTEG_W-1]) begin
      sum_next = sum_wide[INTEG_W] ? I32_MIN : I32_MAX;
    end else begin
      sum_next = sum_wide[INTEG_W-1:0];
    end
  end

  // Current command clamped to the current limit.
  always_comb begin
    if (quot > Q_LIM) begin
      cmd_next = CURR_MAX;
    end else if (quot < -Q_LIM) begin
      cmd_next = CURR_MIN;
    end else begin
      cmd_next = quot[CURR_W-1:0];
    end
  end

  // Angle unwrap: a large negative step is a turn forward, a large positive one a turn back.
  assign angle_diff = $signed({{(DIFF_W-ANGLE_W){1'b0}}, item_angle}) -
                      $signed({{(DIFF_W-ANGLE_W){1'b0}}, angle});
  always_comb begin
    if (angle_diff < -WRAP_LIM) begin
      turns_next = turns + 1'b1;
    end else if (angle_diff > WRAP_LIM) begin
      turns_next = turns - 1'b1;
    end else begin
      turns_next = turns;
    end
  end

  // Multi-turn position, wrapped to its field width.
  assign pos_calc = POS_CALC_W'(turns) * POS_CALC_W'(COUNTS_PER_TURN) +
                    POS_CALC_W'({1'b0, angle});

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      position_gain   <= '0;
      speed_prop_gain <= SPEED_PROP_GAIN_RST;
      speed_int_gain  <= SPEED_INT_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_TARGET_POSITION: target_position <= cfg_data[POS_W-1:0];
        CFG_POSITION_GAIN:   position_gain   <= cfg_data[GAIN_W-1:0];
        CFG_SPEED_PROP_GAIN: speed_prop_gain <= cfg_data[GAIN_W-1:0];
        CFG_SPEED_INT_GAIN:  speed_int_gain  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input item capture.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item_tick  <= s_tuser;
      item_angle <= s_tdata[ANGLE_W-1:0];
      item_speed <= s_tdata[ANGLE_W+SPEED_W-1:ANGLE_W];
    end
  end

  // Controller state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle           <= '0;
      turns           <= '0;
      stored_speed    <= '0;
      speed_error_sum <= '0;
      last_command    <= '0;
      position        <= '0;
    end else begin
      if (ctrl.uop.fb_en) begin
        angle        <= item_angle;
        turns        <= turns_next;
        stored_speed <= item_speed;
      end
      if (ctrl.uop.pos_en) begin
        position <= pos_calc[POS_W-1:0];
      end
      if (ctrl.uop.sum_en) begin
        speed_error_sum <= sum_next;
      end
      if (ctrl.uop.cmd_en) begin
        last_command <= cmd_next;
      end
    end
  end

  // Working registers of the cascade computation.
  always_ff @(posedge clk) begin
    if (ctrl.uop.err_en) begin
      err <= {target_position[POS_W-1], target_position} - {position[POS_W-1], position};
    end
    if (ctrl.uop.mul_sel != MUL_NONE) begin
      prod <= mul_p;
    end
    case (ctrl.uop.acc_op)
      ACC_NUM:  acc <= ACC_W'(prod) - speed_term;
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      default:  ;
    endcase
    if (ctrl.uop.verr_en) begin
      verr <= verr_next;
    end
  end

  // Output register: one transaction per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.uop.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uop.done) begin
      m_tuser      <= item_tick;
      out_current  <= last_command;
      out_turns    <= turns;
      out_position <= position;
    end
  end

  assign m_tdata = {{(M_TDATA_W-POS_W-TURNS_W-CURR_W){1'b0}},
                    out_position, out_turns, out_current};

endmodule

`default_nettype wire

// ===== rtl/cascade_motor_position_controller_unit.sv =====
// Top level of the cascade position and velocity PI motor controller.
//
// Input stream: each transaction is either a feedback sample (tuser low) carrying
// the encoder angle and the measured speed, or a control tick (tuser high) that
// runs the position loop, the velocity PI loop and produces a current command.
// Output stream: exactly one transaction per input transaction, carrying the
// command (fresh on a tick, held on feedback), the turn count and the multi-turn
// position; tuser marks a fresh command.
// Configuration: write enable, register index and data; to be written only while
// idle, a rule for the user that the block itself does not enforce.
// Timing: a small control program steps a single shared 33x32 multiplier and an
// accumulator; the result is registered and visible on the cycle after the last
// step. The input is ready again in the cycle after the last step, so a new item
// is accepted only once the current one is through.
// Stalls: a finished result waits in the output register while the next item is
// accepted and worked on; that item's last step waits until the output is free.
// Reset: synchronous; clears controller state, restores register defaults and
// empties the output register.
`default_nettype none

module cascade_motor_position_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [12:0] encoder_angle, [28:13] measured_speed, [31:29] zero
  input  logic [cmpc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [0] action
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [13:0] drive_current, [29:14] turn_count, [58:30] multi_turn_position, [63:59] zero
  output logic [cmpc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [0] command_valid
  output logic                                m_axis_tuser,
  input  logic                                cfg_we,
  input  logic [cmpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cmpc_pkg::*;

  seq_ctrl_t  ctrl;
  dp_status_t status;

  // Program sequencer.
  cmpc_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .status  (status),
    .ctrl    (ctrl)
  );

  // Arithmetic and state.
  cmpc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/cmpc_checker.sv =====
// Port-level assertions for the controller and the bind that attaches them.
`default_nettype none

module cmpc_port_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [cmpc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input logic                                m_axis_tuser
);
  import cmpc_pkg::*;

  localparam logic signed [CURR_W-1:0] LIM = CURR_W'(CURRENT_LIMIT);

  // The command on the output never exceeds the current limit.
  a_current_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (($signed(m_axis_tdata[CURR_W-1:0]) <= LIM) &&
                       ($signed(m_axis_tdata[CURR_W-1:0]) >= -LIM)))
    else $error("drive current outside the current limit");

  // One item at a time: the input closes right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready while an item is in progress");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output transaction changed");

endmodule

bind cascade_motor_position_controller_unit cmpc_port_checker u_cmpc_port_checker (.*);

`default_nettype wire
